>>> design/lmssc_pkg.sv
// Shared types, codes and constants of the lid motor stall and speed controller.
// Used by the channel interfaces and by the controller core; depends on nothing.

package lmssc_pkg;

    // Field widths fixed by the item and result formats.
    localparam int POS_W   = 16;
    localparam int CNT_W   = 8;
    localparam int DUTY_W  = 7;
    localparam int EIDX_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Supervisor and drive constants.
    localparam int CHECK_PERIOD = 5;
    localparam int WEAK_LIMIT   = 2;
    localparam int SETTLE_TICKS = 10;
    localparam int DUTY_FULL    = 100;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET_DIR = 2'd1,
        OP_WR_FWD  = 2'd2,
        OP_WR_REV  = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_POS    = 3'd0,
        REG_MAX_POS    = 3'd1,
        REG_ZONE_LOW   = 3'd2,
        REG_ZONE_HIGH  = 3'd3,
        REG_RISING     = 3'd4,
        REG_STALL_MOVE = 3'd5,
        REG_DUTY_TRIM  = 3'd6
    } t_reg;

    // Direction codes.
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // Zone codes.
    localparam logic [1:0] ZONE_LOW  = 2'd0;
    localparam logic [1:0] ZONE_MID  = 2'd1;
    localparam logic [1:0] ZONE_HIGH = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [POS_W-1:0]  position_sample;
        logic [1:0]        direction_cmd;
        logic [EIDX_W-1:0] entry_index;
        logic [DUTY_W-1:0] entry_value;
    } t_item;

    typedef struct packed {
        logic              fwd_enable;
        logic              rev_enable;
        logic [DUTY_W-1:0] fwd_duty;
        logic [DUTY_W-1:0] rev_duty;
        logic [1:0]        zone;
        logic [1:0]        direction;
        logic              stall_stop;
        logic              past_middle;
        logic [EIDX_W-1:0] speed_index;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] value;
    } t_cfg;

    // Counter increment that saturates at the all-ones value.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

>>> design/lmssc_if.sv
// Valid/ready channel interfaces: input items, result items and register writes.
// Payload types come from lmssc_pkg.

interface lmssc_item_if;
    logic              valid;
    logic              ready;
    lmssc_pkg::t_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lmssc_result_if;
    logic               valid;
    logic               ready;
    lmssc_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lmssc_cfg_if;
    logic             valid;
    logic             ready;
    lmssc_pkg::t_cfg  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/lmssc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.

module lmssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lmssc_div.sv
// Iterative restoring divider for the speed index, one quotient bit per cycle.
// The caller guarantees the quotient fits in QW bits. No package needed.

module lmssc_div #(
    parameter int QW = 4,
    parameter int DW = 16,
    localparam int NW = DW + QW,
    localparam int CW = $clog2(QW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_den;
    logic [QW-1:0] r_quot;
    logic          n_ge;
    logic [NW-1:0] n_diff;

    // Trial subtraction of the shifted divisor.
    always_comb begin
        n_ge   = (r_rem >= r_den);
        n_diff = r_rem - r_den;
    end

    // Step sequencer: the divisor starts at its top alignment and moves right.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num;
                r_den  <= NW'(i_den) << (QW - 1);
                r_quot <= '0;
            end else if (r_busy) begin
                if (n_ge) begin
                    r_rem <= n_diff;
                end
                r_quot <= {r_quot[QW-2:0], n_ge};
                r_den  <= r_den >> 1;
                r_cnt  <= r_cnt + CW'(1);
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> design/lid_motor_stall_speed_controller_core.sv
// Lid motor H-bridge controller. Each item is one transaction on i_item: a tick with a
// position sample, a direction command or a speed-table write; every item returns exactly
// one result transaction on o_result. Ticks pass through the clamp, classify and supervise
// steps, the bit-per-cycle speed-index divider (when max exceeds min) and the registered
// speed-table read before the result is loaded; other items go straight to delivery.
// i_item is ready only between items, while a finished result may still wait in the
// output register. Registers are to be written on i_cfg only while the block is idle;
// the block itself does not enforce this. Depends on lmssc_pkg, lmssc_if, lmssc_ram and
// lmssc_div.

module lid_motor_stall_speed_controller_core import lmssc_pkg::*; #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lmssc_cfg_if.sink      i_cfg,
    lmssc_item_if.sink     i_item,
    lmssc_result_if.source o_result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int QW    = $clog2(TABLE_ENTRIES + 1);
    localparam int NW    = POS_W + QW;
    localparam int XW    = IDX_W + EIDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_CLASSIFY,
        S_SUPERVISE,
        S_DIVIDE,
        S_FETCH,
        S_DELIVER
    } t_state;

    // Configuration registers.
    logic [POS_W-1:0] r_min_pos;
    logic [POS_W-1:0] r_max_pos;
    logic [POS_W-1:0] r_zone_lo;
    logic [POS_W-1:0] r_zone_hi;
    logic             r_rising_open;
    logic [POS_W-1:0] r_stall_move;
    logic [7:0]       r_trim;

    // Controller state.
    t_state           r_state;
    logic [1:0]       r_cur_dir;
    logic [1:0]       r_prev_dir;
    logic [CNT_W-1:0] r_same_ticks;
    logic             r_chk_on;
    logic [CNT_W-1:0] r_chk_ticks;
    logic [CNT_W-1:0] r_weak;
    logic [POS_W-1:0] r_prev_pos;
    logic [POS_W-1:0] r_held_pos;

    // Per-item working registers.
    logic             r_tick;
    logic [POS_W-1:0] r_sample;
    logic [1:0]       r_zone;
    logic             r_past_mid;
    logic             r_rising;
    logic [POS_W-1:0] r_moved;
    logic [POS_W-1:0] r_span;
    logic [POS_W-1:0] r_share;
    logic             r_span_ok;
    logic [IDX_W-1:0] r_idx;
    logic             r_stall;

    // Output register.
    logic             r_out_valid;
    t_result          r_result;

    // Combinational helpers.
    logic             w_item_acc;
    logic             w_out_free;
    logic [XW-1:0]    w_eidx_ext;
    logic             w_eidx_ok;
    logic [IDX_W-1:0] w_waddr;
    logic             w_fwd_we;
    logic             w_rev_we;
    logic             w_rd_en;
    logic [DUTY_W-1:0] w_fwd_rdata;
    logic [DUTY_W-1:0] w_rev_rdata;
    logic             w_div_start;
    logic             w_div_done;
    logic [QW-1:0]    w_quot;
    logic [NW-1:0]    w_num;
    logic [POS_W-1:0] n_clamp;
    logic [CNT_W-1:0] n_same_ticks;
    logic             n_chk_on;
    logic [1:0]       n_zone;
    logic [POS_W:0]   w_mid_sum;
    logic [POS_W-1:0] w_mid;
    logic [POS_W-1:0] w_a;
    logic [POS_W-1:0] w_b;
    logic [POS_W:0]   w_ab;
    logic [POS_W-1:0] w_ba;
    logic [CNT_W-1:0] n_chk_ticks;
    logic [CNT_W-1:0] n_weak;
    logic             n_check_due;
    logic [IDX_W-1:0] n_idx;
    logic [DUTY_W-1:0] w_entry;
    logic signed [8:0] w_trim_sum;
    logic [DUTY_W-1:0] w_trimmed;
    logic [XW-1:0]    w_idx_ext;
    t_result          n_result;

    // Register writes; the port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pos     <= '0;
            r_max_pos     <= '1;
            r_zone_lo     <= '0;
            r_zone_hi     <= '1;
            r_rising_open <= 1'b1;
            r_stall_move  <= '0;
            r_trim        <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.payload.index)
                REG_MIN_POS:    r_min_pos     <= i_cfg.payload.value;
                REG_MAX_POS:    r_max_pos     <= i_cfg.payload.value;
                REG_ZONE_LOW:   r_zone_lo     <= i_cfg.payload.value;
                REG_ZONE_HIGH:  r_zone_hi     <= i_cfg.payload.value;
                REG_RISING:     r_rising_open <= i_cfg.payload.value[0];
                REG_STALL_MOVE: r_stall_move  <= i_cfg.payload.value;
                REG_DUTY_TRIM:  r_trim        <= i_cfg.payload.value[7:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake and table write decode.
    assign w_item_acc   = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_eidx_ext   = XW'(i_item.payload.entry_index);
    assign w_eidx_ok    = (w_eidx_ext < XW'(TABLE_ENTRIES));
    assign w_waddr      = w_eidx_ext[IDX_W-1:0];
    assign w_fwd_we     = w_item_acc && w_eidx_ok && (i_item.payload.operation == OP_WR_FWD);
    assign w_rev_we     = w_item_acc && w_eidx_ok && (i_item.payload.operation == OP_WR_REV);
    assign w_rd_en      = (r_state == S_FETCH);

    lmssc_ram #(
        .WIDTH (DUTY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_fwd_table (
        .i_clk   (i_clk),
        .i_we    (w_fwd_we),
        .i_waddr (w_waddr),
        .i_wdata (i_item.payload.entry_value),
        .i_re    (w_rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_fwd_rdata)
    );

    lmssc_ram #(
        .WIDTH (DUTY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_rev_table (
        .i_clk   (i_clk),
        .i_we    (w_rev_we),
        .i_waddr (w_waddr),
        .i_wdata (i_item.payload.entry_value),
        .i_re    (w_rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_rev_rdata)
    );

    // Speed index divider: TABLE_ENTRIES * share / span.
    assign w_div_start = (r_state == S_SUPERVISE) && r_span_ok;
    assign w_num       = NW'(r_share) * NW'(TABLE_ENTRIES);

    lmssc_div #(
        .QW (QW),
        .DW (POS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_span),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Clamp, maximum limit tested first, and direction settling.
    always_comb begin
        if (r_sample > r_max_pos) begin
            n_clamp = r_max_pos;
        end else if (r_sample < r_min_pos) begin
            n_clamp = r_min_pos;
        end else begin
            n_clamp = r_sample;
        end
        n_same_ticks = '0;
        n_chk_on     = 1'b0;
        if (r_cur_dir != DIR_STOP && r_prev_dir == r_cur_dir) begin
            n_same_ticks = sat_inc(r_same_ticks);
            n_chk_on     = r_chk_on || (n_same_ticks >= CNT_W'(SETTLE_TICKS));
        end
    end

    // Zone, midpoint and movement since the last check.
    always_comb begin
        if (r_rising_open) begin
            if (r_held_pos <= r_zone_lo) begin
                n_zone = ZONE_LOW;
            end else if (r_held_pos >= r_zone_hi) begin
                n_zone = ZONE_HIGH;
            end else begin
                n_zone = ZONE_MID;
            end
        end else begin
            if (r_held_pos >= r_zone_lo) begin
                n_zone = ZONE_LOW;
            end else if (r_held_pos <= r_zone_hi) begin
                n_zone = ZONE_HIGH;
            end else begin
                n_zone = ZONE_MID;
            end
        end
        w_mid_sum = {1'b0, r_max_pos} + {1'b0, r_min_pos};
        w_mid     = w_mid_sum[POS_W:1];
        if (r_cur_dir == DIR_FWD) begin
            w_a = r_held_pos;
            w_b = r_prev_pos;
        end else begin
            w_a = r_prev_pos;
            w_b = r_held_pos;
        end
        w_ab = {1'b0, w_a} - {1'b0, w_b};
        w_ba = w_b - w_a;
    end

    // Stall check outcome.
    always_comb begin
        n_chk_ticks = sat_inc(r_chk_ticks);
        n_check_due = r_chk_on && (n_chk_ticks >= CNT_W'(CHECK_PERIOD));
        if (r_rising == r_rising_open && r_moved >= r_stall_move) begin
            n_weak = '0;
        end else begin
            n_weak = sat_inc(r_weak);
        end
    end

    // Saturated divider quotient.
    always_comb begin
        if (w_quot >= QW'(TABLE_ENTRIES)) begin
            n_idx = IDX_W'(TABLE_ENTRIES - 1);
        end else begin
            n_idx = w_quot[IDX_W-1:0];
        end
    end

    // Bridge drive from the fetched table entry.
    always_comb begin
        w_entry    = (r_cur_dir == DIR_FWD) ? w_fwd_rdata : w_rev_rdata;
        w_trim_sum = $signed({2'b00, w_entry}) + $signed({r_trim[7], r_trim});
        if (w_trim_sum < 0) begin
            w_trimmed = '0;
        end else if (w_trim_sum > 9'sd100) begin
            w_trimmed = DUTY_W'(DUTY_FULL);
        end else begin
            w_trimmed = w_trim_sum[DUTY_W-1:0];
        end
        w_idx_ext = XW'(r_idx);

        n_result           = '0;
        n_result.direction = r_cur_dir;
        if (r_tick) begin
            n_result.zone        = r_zone;
            n_result.stall_stop  = r_stall;
            n_result.past_middle = r_past_mid;
            n_result.speed_index = w_idx_ext[EIDX_W-1:0];
            if (r_cur_dir == DIR_FWD || r_cur_dir == DIR_REV) begin
                if (w_entry != '0) begin
                    n_result.fwd_enable = 1'b1;
                    n_result.rev_enable = 1'b1;
                    if (r_cur_dir == DIR_FWD) begin
                        n_result.fwd_duty = w_trimmed;
                    end else begin
                        n_result.rev_duty = w_trimmed;
                    end
                end else begin
                    n_result.fwd_duty = DUTY_W'(DUTY_FULL);
                    n_result.rev_duty = DUTY_W'(DUTY_FULL);
                end
            end
        end
    end

    // Sequencer, controller state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur_dir    <= DIR_STOP;
            r_prev_dir   <= DIR_STOP;
            r_same_ticks <= '0;
            r_chk_on     <= 1'b0;
            r_chk_ticks  <= '0;
            r_weak       <= '0;
            r_prev_pos   <= '0;
            r_held_pos   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_item_acc) begin
                        r_sample <= i_item.payload.position_sample;
                        r_tick   <= (i_item.payload.operation == OP_TICK);
                        if (i_item.payload.operation == OP_TICK) begin
                            r_state <= S_CLAMP;
                        end else begin
                            if (i_item.payload.operation == OP_SET_DIR) begin
                                if (i_item.payload.direction_cmd == DIR_FWD ||
                                    i_item.payload.direction_cmd == DIR_REV) begin
                                    r_cur_dir <= i_item.payload.direction_cmd;
                                end else begin
                                    r_cur_dir <= DIR_STOP;
                                end
                            end
                            r_state <= S_DELIVER;
                        end
                    end
                end
                S_CLAMP: begin
                    r_held_pos   <= n_clamp;
                    r_same_ticks <= n_same_ticks;
                    r_chk_on     <= n_chk_on;
                    r_stall      <= 1'b0;
                    r_state      <= S_CLASSIFY;
                end
                S_CLASSIFY: begin
                    r_zone     <= n_zone;
                    r_past_mid <= r_rising_open ? (r_held_pos > w_mid) : (r_held_pos < w_mid);
                    r_rising   <= !w_ab[POS_W];
                    r_moved    <= w_ab[POS_W] ? w_ba : w_ab[POS_W-1:0];
                    r_span     <= r_max_pos - r_min_pos;
                    r_span_ok  <= (r_max_pos > r_min_pos);
                    r_share    <= r_rising_open ? (r_held_pos - r_min_pos)
                                                : (r_max_pos - r_held_pos);
                    r_state    <= S_SUPERVISE;
                end
                S_SUPERVISE: begin
                    r_prev_dir <= r_cur_dir;
                    if (!r_chk_on) begin
                        r_chk_ticks <= '0;
                        r_prev_pos  <= r_held_pos;
                    end else if (!n_check_due) begin
                        r_chk_ticks <= n_chk_ticks;
                    end else begin
                        r_chk_ticks <= '0;
                        r_prev_pos  <= r_held_pos;
                        r_weak      <= n_weak;
                        if (n_weak >= CNT_W'(WEAK_LIMIT)) begin
                            r_cur_dir  <= DIR_STOP;
                            r_prev_dir <= DIR_STOP;
                            r_stall    <= 1'b1;
                        end
                    end
                    if (r_span_ok) begin
                        r_state <= S_DIVIDE;
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_FETCH;
                    end
                end
                S_DIVIDE: begin
                    if (w_div_done) begin
                        r_idx   <= n_idx;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_DELIVER;
                end
                S_DELIVER: begin
                    if (w_out_free) begin
                        r_result    <= n_result;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_result;

`ifndef SYNTHESIS
    // A stall stop always leaves the motor stopped.
    a_stall_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.payload.stall_stop) |->
            (o_result.payload.direction == DIR_STOP))
        else $error("stall stop reported with the motor still running");

    // Running drive enables both high sides and drives only one low side.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.payload.fwd_enable) |->
            (o_result.payload.rev_enable &&
             (o_result.payload.fwd_duty == '0 || o_result.payload.rev_duty == '0)))
        else $error("both low sides driven while running");

    // Duties never exceed full scale.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
            (o_result.payload.fwd_duty <= DUTY_W'(DUTY_FULL) &&
             o_result.payload.rev_duty <= DUTY_W'(DUTY_FULL)))
        else $error("duty above full scale");

    // The divider only finishes while the sequencer waits for it.
    a_div_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIVIDE))
        else $error("divider finished outside the divide step");

    // The table is never read beyond its last entry.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_idx <= IDX_W'(TABLE_ENTRIES - 1)))
        else $error("speed index beyond the table");
`endif

endmodule
